FILE: hw/rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the LIFO stack with search
// Holds the stack geometry, the operation and status codes, the request and
// result item types and the sequencer state type.
// ----------------------------------------------------------------------------
package lss_pkg;

	// Stack geometry.
	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int POS_W       = 6;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [FILL_W-1:0]        fill_t;
	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [POS_W-1:0]         pos_t;

	// Operation codes carried by a request item.
	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_DISPLAY = 2'd3
	} op_t;

	// Status codes carried by a result item.
	typedef enum logic [2:0] {
		ST_PUSHED    = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_POPPED    = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_FOUND     = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_EMPTY     = 3'd6,
		ST_LISTED    = 3'd7
	} status_t;

	typedef struct packed {
		op_t   operation;
		word_t value;
	} req_t;

	typedef struct packed {
		status_t status;
		word_t   data;
		pos_t    position;
		logic    last;
	} res_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_WALK,
		S_FLUSH
	} state_t;

endpackage

FILE: hw/rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack with linear search
// A small sequencer drives one stack memory and one equality compare, and
// walks the stack from top to bottom for search and display.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                    Handshake
//  --------  -----------------------  -------------------------------------
//  request   request (req_t)          taken when start is high, busy low
//  result    result (res_t)           valid for one cycle while strobe high
//
//  Push is answered from idle, pop through S_POP after one memory read;
//  display walks S_WALK, search walks S_WALK and ends in S_FLUSH. The walk
//  reads one memory entry per cycle through the single read port, and a
//  found result is held back one step so that its last flag can be set.
//  Empty/full cases are answered from idle. Reset clears state, fill, pend
//  flag and strobe; the receiver cannot stall, so results leave as formed.
//
module lifo_stack_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lss_pkg::req_t request,
	output logic          strobe,
	output lss_pkg::res_t result
);
	import lss_pkg::*;

	state_t state_q, state_d;
	fill_t  fill_q, fill_d;
	addr_t  ptr_q, ptr_d;
	pos_t   pos_q, pos_d;
	logic   pend_q, pend_d;
	pos_t   pend_pos_q, pend_pos_d;
	op_t    op_q, op_d;
	word_t  key_q, key_d;
	logic   strobe_q, strobe_d;
	res_t   result_q, result_d;

	logic   ram_we;
	addr_t  ram_waddr;
	addr_t  ram_raddr;
	word_t  ram_rdata;
	logic   hit;
	logic   at_bottom;
	logic   full;
	logic   empty;

	lss_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (request.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared compare and walk status.
	assign hit       = (ram_rdata == key_q);
	assign at_bottom = (ptr_q == '0);
	assign full      = (fill_q == fill_t'(STACK_DEPTH));
	assign empty     = (fill_q == '0);
	assign ram_waddr = fill_q[ADDR_W-1:0];

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// Sequencer: next state, memory control and result formation.
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		ptr_d      = ptr_q;
		pos_d      = pos_q;
		pend_d     = pend_q;
		pend_pos_d = pend_pos_q;
		op_d       = op_q;
		key_d      = key_q;
		strobe_d   = 1'b0;
		result_d   = result_q;
		ram_we     = 1'b0;
		ram_raddr  = ptr_q - addr_t'(1);

		unique case (state_q)
			S_IDLE: begin
				ram_raddr = addr_t'(fill_q - fill_t'(1));
				if (start) begin
					op_d            = request.operation;
					key_d           = request.value;
					result_d.data     = '0;
					result_d.position = '0;
					result_d.last     = 1'b1;
					unique case (request.operation)
						OP_PUSH: begin
							strobe_d = 1'b1;
							if (full) begin
								result_d.status = ST_OVERFLOW;
							end else begin
								ram_we          = 1'b1;
								fill_d          = fill_q + fill_t'(1);
								result_d.status = ST_PUSHED;
							end
						end
						OP_POP: begin
							if (empty) begin
								strobe_d        = 1'b1;
								result_d.status = ST_UNDERFLOW;
							end else begin
								fill_d  = fill_q - fill_t'(1);
								state_d = S_POP;
							end
						end
						default: begin
							if (empty) begin
								strobe_d        = 1'b1;
								result_d.status = ST_EMPTY;
							end else begin
								ptr_d   = ram_raddr;
								pos_d   = pos_t'(1);
								pend_d  = 1'b0;
								state_d = S_WALK;
							end
						end
					endcase
				end
			end

			S_POP: begin
				strobe_d          = 1'b1;
				result_d.status   = ST_POPPED;
				result_d.data     = ram_rdata;
				result_d.position = '0;
				result_d.last     = 1'b1;
				state_d           = S_IDLE;
			end

			S_WALK: begin
				ptr_d = ptr_q - addr_t'(1);
				pos_d = pos_q + pos_t'(1);
				if (op_q == OP_DISPLAY) begin
					// Every entry is listed as it comes out of the memory.
					strobe_d          = 1'b1;
					result_d.status   = ST_LISTED;
					result_d.data     = ram_rdata;
					result_d.position = '0;
					result_d.last     = at_bottom;
					if (at_bottom) begin
						state_d = S_IDLE;
					end
				end else begin
					// A match releases the previous match, which is then not last.
					if (hit) begin
						if (pend_q) begin
							strobe_d          = 1'b1;
							result_d.status   = ST_FOUND;
							result_d.data     = '0;
							result_d.position = pend_pos_q;
							result_d.last     = 1'b0;
						end
						pend_d     = 1'b1;
						pend_pos_d = pos_q;
					end
					if (at_bottom) begin
						state_d = S_FLUSH;
					end
				end
			end

			S_FLUSH: begin
				strobe_d          = 1'b1;
				result_d.status   = pend_q ? ST_FOUND : ST_NOT_FOUND;
				result_d.data     = '0;
				result_d.position = pend_q ? pend_pos_q : '0;
				result_d.last     = 1'b1;
				pend_d            = 1'b0;
				state_d           = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			pend_q   <= pend_d;
			strobe_q <= strobe_d;
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		pos_q      <= pos_d;
		pend_pos_q <= pend_pos_d;
		op_q       <= op_d;
		key_q      <= key_d;
		result_q   <= result_d;
	end

endmodule

FILE: hw/rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram: stack storage
// One write port and one read port; read data is registered, so a read
// issued in one cycle is seen in the next.
// ----------------------------------------------------------------------------
module lss_ram (
	input  logic          clk,
	input  logic          we,
	input  lss_pkg::addr_t waddr,
	input  lss_pkg::word_t wdata,
	input  lss_pkg::addr_t raddr,
	output lss_pkg::word_t rdata
);
	import lss_pkg::*;

	word_t mem [STACK_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
